// File: src/camera_point_projection_defines.svh
// Assertion macros for the camera point projection RTL.
`ifndef CAMERA_POINT_PROJECTION_DEFINES_SVH
`define CAMERA_POINT_PROJECTION_DEFINES_SVH

`ifndef SYNTHESIS
// Concurrent assertion on an explicit clock and active-low reset.
`define CPP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Concurrent assertion on the block clock and reset.
`define CPP_ASSERT(lbl, prop, msg) \
  `CPP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define CPP_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define CPP_ASSERT(lbl, prop, msg)
`endif

`endif

// File: src/cpp_pkg.sv
// Shared types and constants of the camera point projection block.
`timescale 1ns / 1ps

package cpp_pkg;

  // Fraction bits of the trig registers and their width.
  localparam int FRAC_BITS = 14;
  localparam int TRIG_W    = 16;
  localparam int FOCAL_W   = 16;
  localparam int OUT_W     = 16;

  // Quotient bits resolved by the divider; larger quotients saturate.
  localparam int QUO_W = 17;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CAMERA_X  = 3'd0,
    REG_CAMERA_Y  = 3'd1,
    REG_CAMERA_Z  = 3'd2,
    REG_COS_YAW   = 3'd3,
    REG_SIN_YAW   = 3'd4,
    REG_COS_PITCH = 3'd5,
    REG_SIN_PITCH = 3'd6,
    REG_FOCAL     = 3'd7
  } cpp_reg_e;

  // Per-item flags that travel beside the divider data.
  typedef struct packed {
    logic front;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } cpp_side_t;

endpackage

// File: src/cpp_rotate.sv
// Two-stage fixed-point plane rotation with floor scaling by 2^14.
`timescale 1ns / 1ps

module cpp_rotate import cpp_pkg::*; #(
  parameter int AW = 25,
  parameter int BW = 25,
  localparam int OW = ((AW > BW) ? AW : BW) + TRIG_W + 1 - FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  input  logic signed [TRIG_W-1:0] sin_i,
  output logic                     valid_o,
  output logic signed [OW-1:0]     u_o,
  output logic signed [OW-1:0]     v_o
);

  localparam int PA = AW + TRIG_W;
  localparam int PB = BW + TRIG_W;
  localparam int SW = OW + FRAC_BITS;

  logic signed [PA-1:0] ac_q, as_q;
  logic signed [PB-1:0] bc_q, bs_q;
  logic signed [SW-1:0] sum_u, sum_v;
  logic                 vld1_q, vld2_q;
  logic signed [OW-1:0] u_q, v_q;

  // First stage: the four products.
  always_ff @(posedge clk_i) begin
    ac_q <= PA'(a_i) * PA'(cos_i);
    as_q <= PA'(a_i) * PA'(sin_i);
    bc_q <= PB'(b_i) * PB'(cos_i);
    bs_q <= PB'(b_i) * PB'(sin_i);
  end

  // Second stage: sums, then an arithmetic shift rounds toward minus infinity.
  assign sum_u = SW'(ac_q) - SW'(bs_q);
  assign sum_v = SW'(as_q) + SW'(bc_q);

  always_ff @(posedge clk_i) begin
    u_q <= OW'(sum_u >>> FRAC_BITS);
    v_q <= OW'(sum_v >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  assign valid_o = vld2_q;
  assign u_o     = u_q;
  assign v_o     = v_q;

endmodule

// File: src/cpp_divider.sv
// Pipelined restoring divider: one quotient bit per stage, two numerators.
`timescale 1ns / 1ps

module cpp_divider import cpp_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NW-1:0]    num_x_i,
  input  logic [NW-1:0]    num_y_i,
  input  logic [DW-1:0]    den_i,
  input  cpp_side_t        side_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_x_o,
  output logic [QUO_W-1:0] quo_y_o,
  output cpp_side_t        side_o
);

  localparam int RW = ((NW > DW + QUO_W) ? NW : DW + QUO_W) + 1;

  logic             vld_q   [QUO_W];
  logic [RW-1:0]    rem_x_q [QUO_W];
  logic [RW-1:0]    rem_y_q [QUO_W];
  logic [QUO_W-1:0] quo_x_q [QUO_W];
  logic [QUO_W-1:0] quo_y_q [QUO_W];
  logic [DW-1:0]    den_q   [QUO_W];
  cpp_side_t        side_q  [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int K = QUO_W - 1 - s;

    logic             vld_in;
    logic [RW-1:0]    rx_in, ry_in, shifted, rx_d, ry_d;
    logic [QUO_W-1:0] qx_in, qy_in;
    logic [DW-1:0]    den_in;
    cpp_side_t        side_in;
    logic             gx, gy;

    // Stage input: the ports for the first stage, the previous stage after that.
    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rx_in   = RW'(num_x_i);
      assign ry_in   = RW'(num_y_i);
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rx_in   = rem_x_q[s-1];
      assign ry_in   = rem_y_q[s-1];
      assign qx_in   = quo_x_q[s-1];
      assign qy_in   = quo_y_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Compare against the shifted divisor and subtract where it fits.
    assign shifted = RW'(den_in) << K;
    assign gx      = (rx_in >= shifted);
    assign gy      = (ry_in >= shifted);
    assign rx_d    = gx ? (rx_in - shifted) : rx_in;
    assign ry_d    = gy ? (ry_in - shifted) : ry_in;

    always_ff @(posedge clk_i) begin
      rem_x_q[s] <= rx_d;
      rem_y_q[s] <= ry_d;
      quo_x_q[s] <= {qx_in[QUO_W-2:0], gx};
      quo_y_q[s] <= {qy_in[QUO_W-2:0], gy};
      den_q[s]   <= den_in;
      side_q[s]  <= side_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_x_o = quo_x_q[QUO_W-1];
  assign quo_y_o = quo_y_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

// File: src/camera_point_projection.sv
// Camera point projection top level: config registers and projection pipeline.
//
// The block projects one 3D point per clock. busy_o never rises, so a point may be
// started in every cycle. Its result appears for one cycle, marked by
// result_valid_o; the receiver cannot stall and must take it then. The
// divider resolves one of its 17 quotient bits per stage, and eight further
// stages serve the offset, the two rotations, the focal
// multiply, the magnitude step and the screen offset. Configuration takes effect
// on the next accepted point and must be written while no point is in flight.
`timescale 1ns / 1ps

`include "camera_point_projection_defines.svh"

module camera_point_projection import cpp_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1280,
  parameter int SCREEN_HEIGHT = 720,
  parameter int COORD_BITS    = 24,
  localparam int CFG_W = (COORD_BITS > TRIG_W) ? COORD_BITS : TRIG_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_data_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  output logic                         result_valid_o,
  output logic signed [OUT_W-1:0]      screen_x_o,
  output logic signed [OUT_W-1:0]      screen_y_o,
  output logic                         in_front_o
);

  localparam int DFW     = COORD_BITS + 1;
  localparam int R1W     = DFW + TRIG_W + 1 - FRAC_BITS;
  localparam int R2W     = R1W + TRIG_W + 1 - FRAC_BITS;
  localparam int PXW     = R1W + FOCAL_W + 1;
  localparam int PYW     = R2W + FOCAL_W + 1;
  localparam int NW      = (PXW > PYW) ? PXW : PYW;
  localparam int DEN_W   = R2W - 1;
  localparam int SUMW    = QUO_W + 3;
  localparam int LATENCY = QUO_W + 8;
  localparam int HALF_W  = SCREEN_WIDTH / 2;
  localparam int HALF_H  = SCREEN_HEIGHT / 2;
  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(32767);
  localparam logic signed [SUMW-1:0] SAT_LO = -SUMW'(32768);

  // Configuration registers.
  logic signed [COORD_BITS-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic signed [TRIG_W-1:0]     cos_yaw_q, sin_yaw_q, cos_pitch_q, sin_pitch_q;
  logic [FOCAL_W-1:0]           focal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q     <= '0;
      cam_y_q     <= '0;
      cam_z_q     <= '0;
      cos_yaw_q   <= TRIG_W'(16384);
      sin_yaw_q   <= '0;
      cos_pitch_q <= TRIG_W'(16384);
      sin_pitch_q <= '0;
      focal_q     <= FOCAL_W'(640);
    end else if (cfg_we_i) begin
      unique case (cpp_reg_e'(cfg_idx_i))
        REG_CAMERA_X:  cam_x_q     <= cfg_data_i[COORD_BITS-1:0];
        REG_CAMERA_Y:  cam_y_q     <= cfg_data_i[COORD_BITS-1:0];
        REG_CAMERA_Z:  cam_z_q     <= cfg_data_i[COORD_BITS-1:0];
        REG_COS_YAW:   cos_yaw_q   <= cfg_data_i[TRIG_W-1:0];
        REG_SIN_YAW:   sin_yaw_q   <= cfg_data_i[TRIG_W-1:0];
        REG_COS_PITCH: cos_pitch_q <= cfg_data_i[TRIG_W-1:0];
        REG_SIN_PITCH: sin_pitch_q <= cfg_data_i[TRIG_W-1:0];
        REG_FOCAL:     focal_q     <= cfg_data_i[FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline takes an item in every cycle.
  assign busy_o = 1'b0;

  // Stage: offset from the camera.
  logic                  vld_d_q;
  logic signed [DFW-1:0] dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i) begin
    dx_q <= DFW'(point_x_i) - DFW'(cam_x_q);
    dy_q <= DFW'(point_y_i) - DFW'(cam_y_q);
    dz_q <= DFW'(point_z_i) - DFW'(cam_z_q);
  end

  // Yaw rotation about Y; dy rides alongside.
  logic                  vld_yaw;
  logic signed [R1W-1:0] rx_w, tz_w;
  logic signed [DFW-1:0] dy1_q, dy2_q;

  cpp_rotate #(.AW(DFW), .BW(DFW)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_d_q),
    .a_i     (dx_q),
    .b_i     (dz_q),
    .cos_i   (cos_yaw_q),
    .sin_i   (sin_yaw_q),
    .valid_o (vld_yaw),
    .u_o     (rx_w),
    .v_o     (tz_w)
  );

  // Pitch rotation about X; rx rides alongside.
  logic                  vld_pitch;
  logic signed [R2W-1:0] ry_w, rz_w;
  logic signed [R1W-1:0] rx1_q, rx2_q;

  cpp_rotate #(.AW(DFW), .BW(R1W)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_yaw),
    .a_i     (dy2_q),
    .b_i     (tz_w),
    .cos_i   (cos_pitch_q),
    .sin_i   (sin_pitch_q),
    .valid_o (vld_pitch),
    .u_o     (ry_w),
    .v_o     (rz_w)
  );

  always_ff @(posedge clk_i) begin
    dy1_q <= dy_q;
    dy2_q <= dy1_q;
    rx1_q <= rx_w;
    rx2_q <= rx1_q;
  end

  // Stage: scale by the focal length.
  logic                  vld_m_q;
  logic signed [PXW-1:0] px_q;
  logic signed [PYW-1:0] py_q;
  logic signed [R2W-1:0] rz_q;

  always_ff @(posedge clk_i) begin
    px_q <= PXW'(rx2_q) * PXW'(signed'({1'b0, focal_q}));
    py_q <= PYW'(ry_w) * PYW'(signed'({1'b0, focal_q}));
    rz_q <= rz_w;
  end

  // Stage: magnitudes, signs, cull test and quotient overflow test.
  logic [NW-1:0]    mag_x, mag_y;
  logic [DEN_W-1:0] den;
  cpp_side_t        side_d;
  logic             vld_a_q;
  logic [NW-1:0]    mag_x_q, mag_y_q;
  logic [DEN_W-1:0] den_q;
  cpp_side_t        side_q;

  assign mag_x        = NW'(px_q[PXW-1] ? unsigned'(-px_q) : unsigned'(px_q));
  assign mag_y        = NW'(py_q[PYW-1] ? unsigned'(-py_q) : unsigned'(py_q));
  assign den          = rz_q[DEN_W-1:0];
  assign side_d.front = !rz_q[R2W-1] && (rz_q != '0);
  assign side_d.neg_x = px_q[PXW-1];
  assign side_d.neg_y = py_q[PYW-1];
  assign side_d.ovf_x = (mag_x >> QUO_W) >= NW'(den);
  assign side_d.ovf_y = (mag_y >> QUO_W) >= NW'(den);

  always_ff @(posedge clk_i) begin
    mag_x_q <= mag_x;
    mag_y_q <= mag_y;
    den_q   <= den;
    side_q  <= side_d;
  end

  // Divider pipeline.
  logic             vld_div;
  logic [QUO_W-1:0] quo_x, quo_y;
  cpp_side_t        side_div;

  cpp_divider #(.NW(NW), .DW(DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_a_q),
    .num_x_i (mag_x_q),
    .num_y_i (mag_y_q),
    .den_i   (den_q),
    .side_i  (side_q),
    .valid_o (vld_div),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y),
    .side_o  (side_div)
  );

  // Output stage: sign, screen center and saturation.
  logic [QUO_W:0]         qx_mag, qy_mag;
  logic signed [SUMW-1:0] qx_s, qy_s, col, row;
  logic signed [OUT_W-1:0] col_sat, row_sat;
  logic                   vld_o_q, front_q;
  logic signed [OUT_W-1:0] sx_q, sy_q;

  assign qx_mag = side_div.ovf_x ? (QUO_W+1)'(1) << QUO_W : {1'b0, quo_x};
  assign qy_mag = side_div.ovf_y ? (QUO_W+1)'(1) << QUO_W : {1'b0, quo_y};
  assign qx_s   = side_div.neg_x ? -signed'(SUMW'(qx_mag)) : signed'(SUMW'(qx_mag));
  assign qy_s   = side_div.neg_y ? -signed'(SUMW'(qy_mag)) : signed'(SUMW'(qy_mag));
  assign col    = SUMW'(HALF_W) + qx_s;
  assign row    = SUMW'(HALF_H) - qy_s;

  always_comb begin
    priority if (col > SAT_HI) begin
      col_sat = OUT_W'(SAT_HI);
    end else if (col < SAT_LO) begin
      col_sat = OUT_W'(SAT_LO);
    end else begin
      col_sat = OUT_W'(col);
    end
    priority if (row > SAT_HI) begin
      row_sat = OUT_W'(SAT_HI);
    end else if (row < SAT_LO) begin
      row_sat = OUT_W'(SAT_LO);
    end else begin
      row_sat = OUT_W'(row);
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q    <= side_div.front ? col_sat : '0;
    sy_q    <= side_div.front ? row_sat : '0;
    front_q <= side_div.front;
  end

  // Valid bits of the stages owned by the top level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
      vld_m_q <= 1'b0;
      vld_a_q <= 1'b0;
      vld_o_q <= 1'b0;
    end else begin
      vld_d_q <= start_i && !busy_o;
      vld_m_q <= vld_pitch;
      vld_a_q <= vld_m_q;
      vld_o_q <= vld_div;
    end
  end

  assign result_valid_o = vld_o_q;
  assign screen_x_o     = sx_q;
  assign screen_y_o     = sy_q;
  assign in_front_o     = front_q && vld_o_q;

  // Every result traces back to an item accepted a fixed latency earlier.
  `CPP_ASSERT(a_latency, result_valid_o |-> $past(start_i, LATENCY), "result without item")
  // A culled item reports the origin.
  `CPP_ASSERT(a_culled_zero, (result_valid_o && !in_front_o) |-> ((screen_x_o == '0) && (screen_y_o == '0)), "culled item not zero")
  // An item in front never reaches the divider with a zero divisor.
  `CPP_ASSERT_CLK(a_den_nonzero, clk_i, rst_ni, (vld_a_q && side_q.front) |-> (den_q != '0), "zero divisor in front")

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the camera point projection block.
`timescale 1ns / 1ps

module tb_top import cpp_pkg::*; ();

  localparam int W      = 1280;
  localparam int H      = 720;
  localparam int CB     = 24;
  localparam int CFG_W  = 24;
  localparam int LAT    = 25;
  localparam int N_RAND = 500;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               front;
  } proj_t;

  // One row of directed stimulus; chk says whether the typed result is compared.
  typedef struct {
    logic signed [CB-1:0] px, py, pz;
    bit                   chk;
    proj_t                res;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  cpp_reg_e             cfg_idx = REG_CAMERA_X;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CB-1:0] pt_x = '0, pt_y = '0, pt_z = '0;
  logic                 res_valid;
  logic signed [15:0]   scr_x, scr_y;
  logic                 front;

  // Shadow copy of the camera registers.
  logic signed [CB-1:0] cam_x, cam_y, cam_z;
  logic signed [15:0]   c_yaw, s_yaw, c_pitch, s_pitch;
  logic [15:0]          focal;

  proj_t pending_proj[$];
  int    errors = 0;
  bit    no_idle = 0;

  camera_point_projection #(.SCREEN_WIDTH(W), .SCREEN_HEIGHT(H), .COORD_BITS(CB)) u_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .start_i(start), .busy_o(busy),
    .point_x_i(pt_x), .point_y_i(pt_y), .point_z_i(pt_z),
    .result_valid_o(res_valid), .screen_x_o(scr_x), .screen_y_o(scr_y),
    .in_front_o(front)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("camera_point_projection test failed");
    $finish;
  end

  // Arithmetic shift floors toward minus infinity, as the rotations need.
  function automatic longint scale_down(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic proj_t project_point(logic signed [CB-1:0] px, py, pz);
    longint dx, dy, dz, rx, tz, ry, rz, qx, qy;
    proj_t  r;
    dx = longint'(px) - longint'(cam_x);
    dy = longint'(py) - longint'(cam_y);
    dz = longint'(pz) - longint'(cam_z);
    rx = scale_down(dx * c_yaw - dz * s_yaw);
    tz = scale_down(dx * s_yaw + dz * c_yaw);
    ry = scale_down(dy * c_pitch - tz * s_pitch);
    rz = scale_down(dy * s_pitch + tz * c_pitch);
    r = '0;
    if (rz > 0) begin
      // SystemVerilog division truncates toward zero.
      qx = (rx * longint'(focal)) / rz;
      qy = (ry * longint'(focal)) / rz;
      r.sx = clamp16(W / 2 + qx);
      r.sy = clamp16(H / 2 - qy);
      r.front = 1'b1;
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Compare each result with the oldest projection still owed.
  always @(posedge clk) begin
    if (rst_n && res_valid) begin
      if (pending_proj.size() == 0) begin
        report("unexpected result", scr_x, 0);
      end else begin
        proj_t e;
        e = pending_proj.pop_front();
        if (scr_x !== e.sx) report("screen_x", scr_x, e.sx);
        if (scr_y !== e.sy) report("screen_y", scr_y, e.sy);
        if (front !== e.front) report("in_front", front, e.front);
      end
    end
  end

  // One register write, then a wait with the write enable low.
  task automatic write_reg(cpp_reg_e idx, longint val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAMERA_X:  cam_x = val[CB-1:0];
      REG_CAMERA_Y:  cam_y = val[CB-1:0];
      REG_CAMERA_Z:  cam_z = val[CB-1:0];
      REG_COS_YAW:   c_yaw = val[15:0];
      REG_SIN_YAW:   s_yaw = val[15:0];
      REG_COS_PITCH: c_pitch = val[15:0];
      REG_SIN_PITCH: s_pitch = val[15:0];
      REG_FOCAL:     focal = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait until the pipeline has drained so registers may change.
  task automatic drain();
    int n;
    n = 0;
    while (pending_proj.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (LAT + 4) @(posedge clk);
  endtask

  // Present one point, hold until accepted, then maybe idle for a burst.
  task automatic send_point(logic signed [CB-1:0] px, py, pz);
    start <= 1'b1;
    pt_x <= px;
    pt_y <= py;
    pt_z <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_proj = {pending_proj, project_point(px, py, pz)};
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  function automatic logic signed [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($signed($urandom_range(0, 4000)) - 2000);
      default: return CB'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  // Pick random but mostly sensible camera settings.
  task automatic random_camera();
    int     a;
    longint c, s;
    a = $urandom_range(0, 3);
    write_reg(REG_CAMERA_X, $signed($urandom_range(0, 20000)) - 10000);
    write_reg(REG_CAMERA_Y, $signed($urandom_range(0, 20000)) - 10000);
    write_reg(REG_CAMERA_Z, $signed($urandom_range(0, 20000)) - 10000);
    c = (a == 0) ? $signed($urandom_range(0, 65535)) - 32768 : 16384 - $urandom_range(0, 3000);
    s = (a == 0) ? $signed($urandom_range(0, 65535)) - 32768 : $signed($urandom_range(0, 6000)) - 3000;
    write_reg(REG_COS_YAW, c);
    write_reg(REG_SIN_YAW, s);
    write_reg(REG_COS_PITCH, 16384 - $urandom_range(0, 3000));
    write_reg(REG_SIN_PITCH, $signed($urandom_range(0, 6000)) - 3000);
    write_reg(REG_FOCAL, (a == 1) ? 65535 : $urandom_range(1, 2000));
  endtask

  row_t dir_rows[$];

  function automatic row_t mk(longint x, longint y, longint z, bit c, longint ex = 0,
                              longint ey = 0, bit ef = 0);
    row_t r;
    r.px = x[CB-1:0];
    r.py = y[CB-1:0];
    r.pz = z[CB-1:0];
    r.chk = c;
    r.res.sx = ex[15:0];
    r.res.sy = ey[15:0];
    r.res.front = ef;
    return r;
  endfunction

  initial begin
    proj_t  p;
    int     mode;
    cam_x = 0; cam_y = 0; cam_z = 0;
    c_yaw = 16384; s_yaw = 0; c_pitch = 16384; s_pitch = 0; focal = 640;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under the reset settings: depth zero culls, a point behind
    // the camera culls, on axis, plain projection, three saturating rows, an
    // unchecked far corner, a far point behind, and truncation toward zero.
    dir_rows = '{
      mk(0, 0, 0, 1, 0, 0, 0),
      mk(0, 0, -100, 1, 0, 0, 0),
      mk(0, 0, 100, 1, W / 2, H / 2, 1),
      mk(100, 50, 640, 1, W / 2 + 100, H / 2 - 50, 1),
      mk(8388607, 0, 1, 1, 32767, H / 2, 1),
      mk(-8388608, 8388607, 1, 1, -32768, -32768, 1),
      mk(0, -8388608, 1, 1, W / 2, 32767, 1),
      mk(-8388608, -8388608, 8388607, 0),
      mk(8388607, 8388607, -8388608, 1, 0, 0, 0),
      mk(-7, 3, 3, 0)
    };
    foreach (dir_rows[i]) begin
      p = project_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz);
      if (dir_rows[i].chk && p !== dir_rows[i].res)
        report("directed table row", i, 0);
      send_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz);
    end
    start <= 1'b0;
    drain();

    // Register extremes: out-of-range trig, zero focal length, far camera.
    write_reg(REG_FOCAL, 0);
    send_point(300, -200, 50);
    send_point(-5, 5, 5);
    start <= 1'b0;
    drain();
    write_reg(REG_CAMERA_X, -8388608);
    write_reg(REG_CAMERA_Y, 8388607);
    write_reg(REG_CAMERA_Z, -8388608);
    write_reg(REG_COS_YAW, -32768);
    write_reg(REG_SIN_YAW, 32767);
    write_reg(REG_COS_PITCH, -16384);
    write_reg(REG_SIN_PITCH, 16384);
    write_reg(REG_FOCAL, 65535);
    send_point(8388607, -8388608, 8388607);
    send_point(-8388608, 8388607, -8388608);
    send_point(0, 0, 0);
    send_point(12345, -54321, 777);
    start <= 1'b0;
    drain();

    // Random phases; each new camera is loaded once the pipeline is empty.
    for (int i = 0; i < N_RAND; i++) begin
      if (i % 100 == 0) begin
        start <= 1'b0;
        drain();
        random_camera();
      end
      no_idle = (i >= N_RAND - 80);
      mode = $urandom_range(0, 9);
      mode = (mode == 0) ? 0 : (mode < 6) ? 1 : 2;
      send_point(rand_coord(mode), rand_coord(mode),
                 CB'(rand_coord(mode == 0 ? 0 : 2) + (mode == 0 ? 0 : 210000)));
    end
    start <= 1'b0;
    drain();

    // Every accepted item must have produced its result.
    if (pending_proj.size() != 0) begin
      report("missing results", pending_proj.size(), 0);
    end

    if (errors == 0) begin
      $display("camera_point_projection test passed");
    end else begin
      $display("camera_point_projection test failed");
    end
    $finish;
  end

endmodule
